/* sv/ssd_free_block_allocator_defines.svh */
// Assertion macros shared by the allocator RTL.
`ifndef SSD_FREE_BLOCK_ALLOCATOR_DEFINES_SVH
`define SSD_FREE_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define SFBA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define SFBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/sfba_pkg.sv */
package sfba_pkg;

	localparam int ENTRY_W       = 10;
	localparam int WAY_FIELD_W   = 2;
	localparam int BLOCK_FIELD_W = 8;
	localparam int CH_FIELD_W    = 3;
	localparam int TOTAL_FIELD_W = 14;
	localparam int STATUS_W      = 2;
	localparam int REG_INDEX_W   = 1;

	localparam int LOW_PERCENT  = 10;
	localparam int HIGH_PERCENT = 25;
	localparam int PERCENT_BASE = 100;

	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

	localparam logic KIND_RETURN   = 1'b0;
	localparam logic KIND_ALLOCATE = 1'b1;

	localparam logic [REG_INDEX_W-1:0] REG_LOW_THRESHOLD  = 1'd0;
	localparam logic [REG_INDEX_W-1:0] REG_HIGH_THRESHOLD = 1'd1;

	typedef logic [ENTRY_W-1:0] entry_t;

endpackage

/* sv/sfba_ram.sv */
module sfba_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/ssd_free_block_allocator.sv */
// Channel  Direction  Handshake                 Payload
// in       request    in_valid / in_ready       kind, start_channel, block_channel,
//                                               block_way, block_number
// out      result     out_valid / out_ready     status, granted_*, next_channel,
//                                               free_total, gc_start, gc_stop
// cfg      write      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One request is in flight at a time; in_ready is high only while the block is idle.
// A return passes from the return state to the result state, where out_valid rises.
// An allocate visits one channel per cycle; a grant passes from the scan state through the
// read state to the result state, where out_valid rises, and a scan that finds nothing
// goes to the result state once every channel has been visited.
// A held result stalls the block until out_ready; cfg_ready is always high.
// Reset needs no clearing pass: unwritten entries come from per-channel way and block counters, not the store.

`include "ssd_free_block_allocator_defines.svh"

module ssd_free_block_allocator import sfba_pkg::*; #(
	parameter int CHANNELS       = 8,
	parameter int WAYS           = 4,
	parameter int BLOCKS_PER_WAY = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     kind,
	input  logic [CH_FIELD_W-1:0]    start_channel,
	input  logic [CH_FIELD_W-1:0]    block_channel,
	input  logic [WAY_FIELD_W-1:0]   block_way,
	input  logic [BLOCK_FIELD_W-1:0] block_number,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [STATUS_W-1:0]      status,
	output logic [CH_FIELD_W-1:0]    granted_channel,
	output logic [WAY_FIELD_W-1:0]   granted_way,
	output logic [BLOCK_FIELD_W-1:0] granted_block,
	output logic [CH_FIELD_W-1:0]    next_channel,
	output logic [TOTAL_FIELD_W-1:0] free_total,
	output logic                     gc_start,
	output logic                     gc_stop,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [REG_INDEX_W-1:0]   cfg_index,
	input  logic [TOTAL_FIELD_W-1:0] cfg_data
);

	localparam int DEPTH = WAYS * BLOCKS_PER_WAY;
	localparam int TOTAL = CHANNELS * DEPTH;
	localparam int IDXW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW  = $clog2(DEPTH + 1);
	localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int TOTW  = $clog2(TOTAL + 1);
	localparam int ADDRW = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int WAYW  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int BLKW  = (BLOCKS_PER_WAY > 1) ? $clog2(BLOCKS_PER_WAY) : 1;
	localparam int RW    = (CHW + 1 > CH_FIELD_W + 1) ? CHW + 1 : CH_FIELD_W + 1;
	localparam int CW    = (TOTW > TOTAL_FIELD_W) ? TOTW : TOTAL_FIELD_W;

	localparam logic [TOTAL_FIELD_W-1:0] LOW_RESET  =
		TOTAL_FIELD_W'(TOTAL * LOW_PERCENT / PERCENT_BASE);
	localparam logic [TOTAL_FIELD_W-1:0] HIGH_RESET =
		TOTAL_FIELD_W'(TOTAL * HIGH_PERCENT / PERCENT_BASE);
	localparam logic [ADDRW-1:0] DEPTH_A   = ADDRW'(DEPTH);
	localparam logic [IDXW-1:0]  IDX_LAST  = IDXW'(DEPTH - 1);
	localparam logic [CNTW-1:0]  CNT_FULL  = CNTW'(DEPTH);
	localparam logic [CHW-1:0]   CH_LAST   = CHW'(CHANNELS - 1);
	localparam logic [WAYW-1:0]  WAY_LAST  = WAYW'(WAYS - 1);
	localparam logic [BLKW-1:0]  BLK_LAST  = BLKW'(BLOCKS_PER_WAY - 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_RET    = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_READ   = 3'd3;
	localparam logic [2:0] ST_RESULT = 3'd4;

	logic [2:0]               state_q;
	logic [CHW-1:0]           ch_q;
	logic [CHW-1:0]           step_q;
	logic                     drop_q;
	logic [WAY_FIELD_W-1:0]   way_q;
	logic [BLOCK_FIELD_W-1:0] num_q;
	logic                     written_q;
	entry_t                   rv_q;
	logic [STATUS_W-1:0]      status_q;
	logic [CH_FIELD_W-1:0]    gch_q;
	logic [WAY_FIELD_W-1:0]   gway_q;
	logic [BLOCK_FIELD_W-1:0] gblk_q;
	logic [CH_FIELD_W-1:0]    next_q;
	logic [TOTW-1:0]          total_q;
	logic [TOTAL_FIELD_W-1:0] low_q;
	logic [TOTAL_FIELD_W-1:0] high_q;

	logic [IDXW-1:0] head_q [CHANNELS];
	logic [IDXW-1:0] tail_q [CHANNELS];
	logic [CNTW-1:0] cnt_q  [CHANNELS];
	logic            wrap_q [CHANNELS];
	logic [WAYW-1:0] hway_q [CHANNELS];
	logic [BLKW-1:0] hblk_q [CHANNELS];

	logic [CHW-1:0]   start_red;
	logic [CHW-1:0]   ch_next;
	logic             ret_ok;
	logic             scan_hit;
	logic [IDXW-1:0]  mem_idx;
	logic [ADDRW-1:0] mem_addr;
	entry_t           mem_rdata;
	entry_t           head_entry;
	logic             grant_zero;

	function automatic logic [CHW-1:0] reduce_channel(input logic [CH_FIELD_W-1:0] v);
		logic [RW-1:0] r;
		r = RW'(v);
		for (int i = 0; i < (1 << CH_FIELD_W); i++) begin
			if (r >= RW'(CHANNELS)) begin
				r = r - RW'(CHANNELS);
			end
		end
		return CHW'(r);
	endfunction

	assign start_red = reduce_channel(start_channel);
	assign ch_next   = (ch_q == CH_LAST) ? '0 : ch_q + 1'b1;

	always_comb begin
		ret_ok = 1'b0;
		if ((state_q == ST_RET) && !drop_q) begin
			ret_ok = (cnt_q[ch_q] != CNT_FULL);
		end
	end

	assign scan_hit   = (state_q == ST_SCAN) && (cnt_q[ch_q] != '0);
	assign mem_idx    = (state_q == ST_RET) ? tail_q[ch_q] : head_q[ch_q];
	assign mem_addr   = ADDRW'(ch_q) * DEPTH_A + ADDRW'(mem_idx);
	assign head_entry = written_q ? mem_rdata : rv_q;

	sfba_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TOTAL)
	) u_store (
		.clk  (clk),
		.we   (ret_ok),
		.waddr(mem_addr),
		.wdata({way_q, num_q}),
		.re   (scan_hit),
		.raddr(mem_addr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			total_q <= TOTW'(TOTAL);
			low_q   <= LOW_RESET;
			high_q  <= HIGH_RESET;
			for (int c = 0; c < CHANNELS; c++) begin
				head_q[c] <= '0;
				tail_q[c] <= '0;
				cnt_q[c]  <= CNT_FULL;
				wrap_q[c] <= 1'b0;
				hway_q[c] <= '0;
				hblk_q[c] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_LOW_THRESHOLD) begin
					low_q <= cfg_data;
				end else if (cfg_index == REG_HIGH_THRESHOLD) begin
					high_q <= cfg_data;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						status_q <= STATUS_OK;
						gch_q    <= '0;
						gway_q   <= '0;
						gblk_q   <= '0;
						next_q   <= CH_FIELD_W'(start_red);
						step_q   <= '0;
						way_q    <= block_way;
						num_q    <= block_number;
						drop_q   <= !(RW'(block_channel) < RW'(CHANNELS));
						if (kind == KIND_RETURN) begin
							ch_q    <= CHW'(block_channel);
							state_q <= ST_RET;
						end else begin
							ch_q    <= start_red;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_RET: begin
					if (ret_ok) begin
						tail_q[ch_q] <= (tail_q[ch_q] == IDX_LAST) ? '0 : tail_q[ch_q] + 1'b1;
						if (tail_q[ch_q] == IDX_LAST) begin
							wrap_q[ch_q] <= 1'b1;
						end
						cnt_q[ch_q] <= cnt_q[ch_q] + 1'b1;
						total_q     <= total_q + 1'b1;
					end else begin
						status_q <= STATUS_DROPPED;
					end
					state_q <= ST_RESULT;
				end
				ST_SCAN: begin
					if (scan_hit) begin
						written_q <= wrap_q[ch_q] || (head_q[ch_q] < tail_q[ch_q]);
						rv_q <= {WAY_FIELD_W'(hway_q[ch_q]), BLOCK_FIELD_W'(hblk_q[ch_q])};
						head_q[ch_q] <= (head_q[ch_q] == IDX_LAST) ? '0 : head_q[ch_q] + 1'b1;
						if (hblk_q[ch_q] == BLK_LAST) begin
							hblk_q[ch_q] <= '0;
							hway_q[ch_q] <= (hway_q[ch_q] == WAY_LAST) ? '0
								: hway_q[ch_q] + 1'b1;
						end else begin
							hblk_q[ch_q] <= hblk_q[ch_q] + 1'b1;
						end
						cnt_q[ch_q] <= cnt_q[ch_q] - 1'b1;
						total_q     <= total_q - 1'b1;
						gch_q       <= CH_FIELD_W'(ch_q);
						next_q      <= CH_FIELD_W'(ch_next);
						state_q     <= ST_READ;
					end else if (step_q == CH_LAST) begin
						status_q <= STATUS_EMPTY;
						state_q  <= ST_RESULT;
					end else begin
						ch_q   <= ch_next;
						step_q <= step_q + 1'b1;
					end
				end
				ST_READ: begin
					gway_q  <= head_entry[ENTRY_W-1 -: WAY_FIELD_W];
					gblk_q  <= head_entry[BLOCK_FIELD_W-1:0];
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready        = (state_q == ST_IDLE);
	assign out_valid       = (state_q == ST_RESULT);
	assign cfg_ready       = 1'b1;
	assign status          = status_q;
	assign granted_channel = gch_q;
	assign granted_way     = gway_q;
	assign granted_block   = gblk_q;
	assign next_channel    = next_q;
	assign free_total      = TOTAL_FIELD_W'(total_q);
	assign gc_start        = (CW'(total_q) <= CW'(low_q));
	assign gc_stop         = (CW'(total_q) >= CW'(high_q));
	assign grant_zero      = (granted_channel == '0) && (granted_way == '0)
		&& (granted_block == '0);

	`SFBA_ASSERT_NOW(a_one_in_flight, out_valid, !in_ready, "request taken with result held")
	`SFBA_ASSERT_NOW(a_empty_zero, out_valid && (status == STATUS_EMPTY), grant_zero, "empty grant")
	`SFBA_ASSERT_NEXT(a_pop_total, scan_hit, total_q == $past(total_q) - 1'b1, "pop kept the total")
	`SFBA_ASSERT_NOW(a_scan_bound, state_q == ST_SCAN, step_q <= CH_LAST, "scan overran")

endmodule
